@@ sv/skp_pkg.sv @@
// ----------------------------------------------------------------------------
// skp_pkg
// Shared types and constants for the skyline profile builder.
// ----------------------------------------------------------------------------
package skp_pkg;

  localparam int CMD_W       = 2;
  localparam int CNT_W       = 4;
  localparam int LABEL_W     = 11;
  localparam int HEIGHT_W    = 11;
  localparam int TOTAL_W     = 20;
  localparam int SLOTS       = 8;
  localparam int SLOT_IW     = 3;
  localparam int MAX_NODES   = 8;
  localparam int SLOT_CAP    = (MAX_NODES < SLOTS) ? MAX_NODES : SLOTS;
  localparam int MAX_EQ_DEF  = 1024;
  localparam logic [LABEL_W-1:0] ACTIVE_SIZE_RST = LABEL_W'(1024);

  typedef enum logic [CMD_W-1:0] {
    CMD_UPDATE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // request and response of the shared add/subtract unit
  typedef struct packed {
    logic               sub;
    logic [TOTAL_W-1:0] a;
    logic [TOTAL_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] sum;
    logic               borrow;
  } alu_rsp_t;

endpackage

@@ sv/skyline_profile_builder_top.sv @@
// ----------------------------------------------------------------------------
// skyline_profile_builder_top
// Skyline column heights of a symmetric sparse matrix, one element at a time.
// ----------------------------------------------------------------------------
// Update: the N slots in use are scanned for the smallest valid label, then
//   each valid label's height is read, compared and, if raised, written back
//   (no step if no label is valid), all on one add/sub unit and the single
//   height RAM port pair. Read returns a stored height; Clear zeroes all.
// One transaction at a time; in_stall is high until the result is registered.
// Reset (rst_n low, synchronous) starts a clearing pass over the height RAM,
//   with in_stall high until it ends.
module skyline_profile_builder_top #(
  parameter int MAX_EQUATIONS = skp_pkg::MAX_EQ_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [skp_pkg::LABEL_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [skp_pkg::CMD_W-1:0]     in_cmd,
  input  logic [skp_pkg::CNT_W-1:0]     in_node_count,
  input  logic [skp_pkg::LABEL_W-1:0]   in_label_a,
  input  logic [skp_pkg::LABEL_W-1:0]   in_label_b,
  input  logic [skp_pkg::LABEL_W-1:0]   in_label_c,
  input  logic [skp_pkg::LABEL_W-1:0]   in_label_d,
  input  logic [skp_pkg::LABEL_W-1:0]   in_label_e,
  input  logic [skp_pkg::LABEL_W-1:0]   in_label_f,
  input  logic [skp_pkg::LABEL_W-1:0]   in_label_g,
  input  logic [skp_pkg::LABEL_W-1:0]   in_label_h,
  input  logic [skp_pkg::LABEL_W-1:0]   in_read_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [skp_pkg::TOTAL_W-1:0]   out_total_length,
  output logic [skp_pkg::HEIGHT_W-1:0]  out_column_height,
  output logic                          out_range_error
);
  import skp_pkg::*;

  localparam int AW = (MAX_EQUATIONS > 1) ? $clog2(MAX_EQUATIONS) : 1;
  localparam int LW = (AW + 1 > LABEL_W) ? AW + 1 : LABEL_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MIN, S_MINM1, S_RD, S_CMP, S_WR, S_RDH, S_RDH2, S_DONE
  } state_t;

  state_t               state_r;
  logic [LABEL_W-1:0]   active_size_r;
  logic [LABEL_W-1:0]   lab_r [SLOTS];
  logic [CNT_W-1:0]     slots_r;
  logic [SLOT_IW-1:0]   k_r;
  logic [SLOTS-1:0]     mask_r;
  logic                 any_r;
  logic                 err_r;
  logic [LABEL_W-1:0]   min_r;
  logic [LABEL_W-1:0]   minm1_r;
  logic [HEIGHT_W-1:0]  h_r;
  logic [HEIGHT_W-1:0]  diff_r;
  logic [AW-1:0]        addr_r;
  logic [HEIGHT_W-1:0]  height_r;
  logic [TOTAL_W-1:0]   total_r;
  logic                 clr_cmd_r;
  logic [AW-1:0]        clr_addr_r;
  logic                 out_valid_r;
  logic [TOTAL_W-1:0]   out_total_r;
  logic [HEIGHT_W-1:0]  out_height_r;
  logic                 out_err_r;

  logic [LW-1:0]        lim;
  logic [SLOT_IW-1:0]   cur_idx;
  logic [SLOT_IW-1:0]   sel_idx;
  logic [LABEL_W-1:0]   lab_sel;
  logic [LABEL_W-1:0]   lab_dec;
  logic                 sel_nz;
  logic                 sel_ok;
  logic                 idx_ok;
  logic [CNT_W-1:0]     cnt_sat;
  logic                 in_acc;
  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [HEIGHT_W-1:0]  ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [HEIGHT_W-1:0]  ram_rdata;

  // effective limit: min(active_size, MAX_EQUATIONS)
  assign lim = (LW'(active_size_r) < LW'(MAX_EQUATIONS)) ?
               LW'(active_size_r) : LW'(MAX_EQUATIONS);

  always_comb begin
    cur_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        cur_idx = SLOT_IW'(i);
      end
    end
  end

  assign sel_idx = (state_r == S_RD) ? cur_idx : k_r;
  assign lab_sel = lab_r[sel_idx];
  assign lab_dec = lab_sel - LABEL_W'(1);
  assign sel_nz  = (lab_sel != '0);
  assign sel_ok  = (LW'(lab_sel) <= lim);
  assign idx_ok  = (in_read_index != '0) && (LW'(in_read_index) <= lim);
  assign cnt_sat = (in_node_count > CNT_W'(SLOT_CAP)) ? CNT_W'(SLOT_CAP) : in_node_count;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    alu_req = '0;
    case (state_r)
      S_MIN: begin
        alu_req.sub = 1'b1;
        alu_req.a   = TOTAL_W'(lab_sel);
        alu_req.b   = TOTAL_W'(min_r);
      end
      S_MINM1: begin
        alu_req.sub = 1'b1;
        alu_req.a   = TOTAL_W'(min_r);
        alu_req.b   = TOTAL_W'(1);
      end
      S_RD: begin
        alu_req.sub = 1'b1;
        alu_req.a   = TOTAL_W'(lab_sel);
        alu_req.b   = TOTAL_W'(minm1_r);
      end
      S_CMP: begin
        alu_req.sub = 1'b1;
        alu_req.a   = TOTAL_W'(h_r);
        alu_req.b   = TOTAL_W'(ram_rdata);
      end
      S_WR: begin
        alu_req.sub = 1'b0;
        alu_req.a   = total_r;
        alu_req.b   = TOTAL_W'(diff_r);
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  skp_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign ram_we    = (state_r == S_CLEAR) || (state_r == S_WR);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_addr_r : addr_r;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : h_r;
  assign ram_raddr = (state_r == S_RD) ? AW'(lab_dec) : addr_r;

  skp_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (MAX_EQUATIONS)
  ) u_height_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      active_size_r <= ACTIVE_SIZE_RST;
      total_r       <= '0;
      clr_addr_r    <= '0;
      clr_cmd_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      mask_r        <= '0;
      any_r         <= 1'b0;
      err_r         <= 1'b0;
      k_r           <= '0;
    end else begin
      if (cfg_we) begin
        active_size_r <= cfg_wdata;
      end
      // in S_DONE the output register is refilled whenever it drains
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(MAX_EQUATIONS - 1)) begin
            state_r <= clr_cmd_r ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            err_r    <= 1'b0;
            height_r <= '0;
            any_r    <= 1'b0;
            mask_r   <= '0;
            k_r      <= '0;
            case (cmd_t'(in_cmd))
              CMD_UPDATE: begin
                lab_r[0] <= in_label_a;
                lab_r[1] <= in_label_b;
                lab_r[2] <= in_label_c;
                lab_r[3] <= in_label_d;
                lab_r[4] <= in_label_e;
                lab_r[5] <= in_label_f;
                lab_r[6] <= in_label_g;
                lab_r[7] <= in_label_h;
                slots_r  <= cnt_sat;
                state_r  <= (cnt_sat == '0) ? S_DONE : S_MIN;
              end
              CMD_READ: begin
                addr_r  <= AW'(in_read_index - LABEL_W'(1));
                err_r   <= !idx_ok;
                state_r <= idx_ok ? S_RDH : S_DONE;
              end
              CMD_CLEAR: begin
                clr_addr_r <= '0;
                clr_cmd_r  <= 1'b1;
                total_r    <= '0;
                state_r    <= S_CLEAR;
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_MIN: begin
          if (sel_nz && !sel_ok) begin
            err_r <= 1'b1;
          end
          if (sel_nz && sel_ok) begin
            mask_r[k_r] <= 1'b1;
            any_r       <= 1'b1;
            if (!any_r || alu_rsp.borrow) begin
              min_r <= lab_sel;
            end
          end
          if (CNT_W'(k_r) + CNT_W'(1) == slots_r) begin
            state_r <= S_MINM1;
          end else begin
            k_r <= k_r + SLOT_IW'(1);
          end
        end
        S_MINM1: begin
          minm1_r <= alu_rsp.sum[LABEL_W-1:0];
          state_r <= any_r ? S_RD : S_DONE;
        end
        S_RD: begin
          if (mask_r == '0) begin
            state_r <= S_DONE;
          end else begin
            mask_r[cur_idx] <= 1'b0;
            h_r             <= alu_rsp.sum[HEIGHT_W-1:0];
            addr_r          <= AW'(lab_dec);
            state_r         <= S_CMP;
          end
        end
        S_CMP: begin
          diff_r <= alu_rsp.sum[HEIGHT_W-1:0];
          // raise only when the new height is strictly larger
          if (!alu_rsp.borrow && (alu_rsp.sum[HEIGHT_W-1:0] != '0)) begin
            state_r <= S_WR;
          end else begin
            state_r <= S_RD;
          end
        end
        S_WR: begin
          total_r <= alu_rsp.sum;
          state_r <= S_RD;
        end
        S_RDH: begin
          state_r <= S_RDH2;
        end
        S_RDH2: begin
          height_r <= ram_rdata;
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_total_r  <= total_r;
            out_height_r <= height_r;
            out_err_r    <= err_r;
            clr_cmd_r    <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_total_length  = out_total_r;
  assign out_column_height = out_height_r;
  assign out_range_error   = out_err_r;

endmodule

@@ sv/skp_ram.sv @@
// ----------------------------------------------------------------------------
// skp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module skp_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/skp_alu.sv @@
// ----------------------------------------------------------------------------
// skp_alu
// Shared add/subtract unit; borrow flags a < b on a subtract.
// ----------------------------------------------------------------------------
module skp_alu (
  input  skp_pkg::alu_req_t req,
  output skp_pkg::alu_rsp_t rsp
);
  import skp_pkg::*;

  logic [TOTAL_W-1:0] b_op;
  logic [TOTAL_W:0]   full;

  assign b_op = req.sub ? ~req.b : req.b;
  assign full = {1'b0, req.a} + {1'b0, b_op} + {{TOTAL_W{1'b0}}, req.sub};

  assign rsp.sum    = full[TOTAL_W-1:0];
  assign rsp.borrow = req.sub & ~full[TOTAL_W];

endmodule

@@ sim/tb_skyline_profile_builder_top.sv @@
// ----------------------------------------------------------------------------
// tb_skyline_profile_builder_top
// Self-checking bench for the skyline profile builder. A short table of
// directed elements, reads and clears runs first, then random traffic under
// several active sizes. Every result is compared field by field against the
// fixed table value if given, else a model of the heights and profile length.
// ----------------------------------------------------------------------------
module tb_skyline_profile_builder_top;
  import skp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES = 6;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [CNT_W-1:0]   node_count;
    logic [LABEL_W-1:0] labels [SLOTS];
    logic [LABEL_W-1:0] read_index;
  } element_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]  total;
    logic [HEIGHT_W-1:0] height;
    logic                err;
  } profile_t;

  typedef struct {
    element_t item;
    bit       fixed;
    profile_t res;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [LABEL_W-1:0]  cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    in_cmd = '0;
  logic [CNT_W-1:0]    in_node_count = '0;
  logic [LABEL_W-1:0]  in_label_a = '0;
  logic [LABEL_W-1:0]  in_label_b = '0;
  logic [LABEL_W-1:0]  in_label_c = '0;
  logic [LABEL_W-1:0]  in_label_d = '0;
  logic [LABEL_W-1:0]  in_label_e = '0;
  logic [LABEL_W-1:0]  in_label_f = '0;
  logic [LABEL_W-1:0]  in_label_g = '0;
  logic [LABEL_W-1:0]  in_label_h = '0;
  logic [LABEL_W-1:0]  in_read_index = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [TOTAL_W-1:0]  out_total_length;
  logic [HEIGHT_W-1:0] out_column_height;
  logic                out_range_error;

  // model state
  logic [HEIGHT_W-1:0] height_model [MAX_EQ_DEF];
  logic [TOTAL_W-1:0]  total_model = '0;
  logic [LABEL_W-1:0]  act_size = ACTIVE_SIZE_RST;

  profile_t    pending_results[$];
  stim_row_t   directed_rows[$];
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          stall_left = 0;
  bit          quiet = 1'b0;

  skyline_profile_builder_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_node_count     (in_node_count),
    .in_label_a        (in_label_a),
    .in_label_b        (in_label_b),
    .in_label_c        (in_label_c),
    .in_label_d        (in_label_d),
    .in_label_e        (in_label_e),
    .in_label_f        (in_label_f),
    .in_label_g        (in_label_g),
    .in_label_h        (in_label_h),
    .in_read_index     (in_read_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_total_length  (out_total_length),
    .out_column_height (out_column_height),
    .out_range_error   (out_range_error)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned eff_limit();
    return (act_size < MAX_EQ_DEF) ? act_size : MAX_EQ_DEF;
  endfunction

  // Applies one transaction to the height model and returns its result.
  function automatic profile_t apply_to_profile(element_t it);
    profile_t           r;
    logic [LABEL_W-1:0] lab [SLOTS];
    int unsigned        lim, slots, low, raise, idx;
    bit                 any;
    r = '0;
    any = 1'b0;
    low = 0;
    lim = eff_limit();
    foreach (lab[k]) lab[k] = '0;
    if (it.cmd == CMD_UPDATE) begin
      slots = (it.node_count > SLOT_CAP) ? SLOT_CAP : it.node_count;
      // minimum over in-range nonzero labels; strays flag and drop out
      for (int k = 0; k < slots; k++) begin
        lab[k] = it.labels[k];
        if (lab[k] > lim) begin
          r.err = 1'b1;
          lab[k] = '0;
        end else if (lab[k] != 0 && (!any || lab[k] < low)) begin
          low = lab[k];
          any = 1'b1;
        end
      end
      for (int k = 0; k < slots; k++) begin
        if (any && lab[k] != 0) begin
          raise = lab[k] - low + 1;
          if (raise > height_model[lab[k] - 1]) begin
            total_model = total_model + TOTAL_W'(raise - height_model[lab[k] - 1]);
            height_model[lab[k] - 1] = HEIGHT_W'(raise);
          end
        end
      end
    end else if (it.cmd == CMD_READ) begin
      idx = it.read_index;
      if (idx == 0 || idx > lim)
        r.err = 1'b1;
      else
        r.height = height_model[idx - 1];
    end else if (it.cmd == CMD_CLEAR) begin
      foreach (height_model[i]) height_model[i] = '0;
      total_model = '0;
    end
    r.total = total_model;
    return r;
  endfunction

  function automatic element_t random_element();
    element_t    it;
    int unsigned lim, pick, base, spread, v;
    lim = eff_limit();
    pick = $urandom_range(0, 199);
    it.cmd = CMD_UPDATE;
    it.node_count = CNT_W'($urandom_range(0, 15));
    it.read_index = LABEL_W'($urandom_range(0, 2047));
    foreach (it.labels[k]) it.labels[k] = LABEL_W'($urandom_range(0, 2047));
    if (pick < 140 && lim != 0) begin
      // labels clustered around a base, with a few holes and strays
      it.node_count = CNT_W'($urandom_range(1, SLOT_CAP));
      spread = ($urandom_range(0, 3) == 0) ? lim : $urandom_range(0, 24);
      base = $urandom_range(1, lim);
      foreach (it.labels[k]) begin
        v = base + $urandom_range(0, spread);
        case ($urandom_range(0, 15))
          0: v = 0;
          1: v = lim + $urandom_range(1, 2047 - lim);
          default: if (v > lim) v = $urandom_range(1, lim);
        endcase
        it.labels[k] = LABEL_W'(v);
      end
    end else if (pick >= 140 && pick < 180) begin
      it.cmd = CMD_READ;
      if (lim != 0 && $urandom_range(0, 9) != 0)
        it.read_index = LABEL_W'($urandom_range(1, lim));
    end else if (pick >= 196 && pick < 199) begin
      it.cmd = CMD_SPARE;
    end else if (pick == 199) begin
      it.cmd = CMD_CLEAR;
    end
    return it;
  endfunction

  task automatic add_row(logic [CMD_W-1:0] cmd, int unsigned cnt, int unsigned lab [SLOTS],
                         int unsigned idx, bit fixed, int unsigned total,
                         int unsigned height, bit err);
    stim_row_t row;
    row.item.cmd = cmd;
    row.item.node_count = CNT_W'(cnt);
    foreach (lab[k]) row.item.labels[k] = LABEL_W'(lab[k]);
    row.item.read_index = LABEL_W'(idx);
    row.fixed = fixed;
    row.res.total = TOTAL_W'(total);
    row.res.height = HEIGHT_W'(height);
    row.res.err = err;
    directed_rows = {directed_rows, row};
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
  endtask

  task automatic send_element(element_t it, bit fixed, profile_t fixed_res);
    profile_t model_res;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= it.cmd;
    in_node_count <= it.node_count;
    in_label_a    <= it.labels[0];
    in_label_b    <= it.labels[1];
    in_label_c    <= it.labels[2];
    in_label_d    <= it.labels[3];
    in_label_e    <= it.labels[4];
    in_label_f    <= it.labels[5];
    in_label_g    <= it.labels[6];
    in_label_h    <= it.labels[7];
    in_read_index <= it.read_index;
    do @(posedge clk); while (in_stall !== 1'b0);
    model_res = apply_to_profile(it);
    if (fixed)
      model_res = fixed_res;
    pending_results = {pending_results, model_res};
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_active_size(logic [LABEL_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    act_size = v;
  endtask

  initial begin : stimulus
    int unsigned sizes [PHASES];
    int          lens [PHASES];
    profile_t    none;
    none = '0;
    foreach (height_model[i]) height_model[i] = '0;
    sizes = '{1024, 1, 0, 2047, 2, 1024};
    sizes[4] = $urandom_range(2, 1023);
    lens = '{300, 60, 40, 300, 300, 200};

    add_row(CMD_READ,   0, '{0, 0, 0, 0, 0, 0, 0, 0}, 1,    1, 0, 0, 0);
    add_row(CMD_READ,   0, '{0, 0, 0, 0, 0, 0, 0, 0}, 0,    1, 0, 0, 1);
    add_row(CMD_READ,   0, '{0, 0, 0, 0, 0, 0, 0, 0}, 1025, 1, 0, 0, 1);
    // no slots in use: labels present but ignored
    add_row(CMD_UPDATE, 0, '{5, 6, 7, 8, 9, 10, 11, 12}, 0, 1, 0, 0, 0);
    add_row(CMD_UPDATE, 2, '{1, 1024, 0, 0, 0, 0, 0, 0}, 0, 1, 1025, 0, 0);
    add_row(CMD_READ,   0, '{0, 0, 0, 0, 0, 0, 0, 0}, 1024, 1, 1025, 1024, 0);
    add_row(CMD_UPDATE, 8, '{1025, 0, 2047, 5, 0, 0, 0, 0}, 0, 1, 1026, 0, 1);
    // slot count saturates
    add_row(CMD_UPDATE, 15, '{3, 4, 5, 6, 7, 8, 9, 10}, 0, 0, 0, 0, 0);
    add_row(CMD_UPDATE, 3, '{0, 0, 0, 700, 800, 900, 1000, 1020}, 0, 0, 0, 0, 0);
    add_row(CMD_UPDATE, 8, '{1500, 1600, 1700, 1800, 1900, 2000, 2046, 2047}, 0, 0, 0, 0, 0);
    add_row(CMD_SPARE,  8, '{1, 2, 3, 4, 5, 6, 7, 8}, 3, 0, 0, 0, 0);
    add_row(CMD_READ,   0, '{0, 0, 0, 0, 0, 0, 0, 0}, 5,    0, 0, 0, 0);
    add_row(CMD_CLEAR,  8, '{1, 2, 3, 4, 5, 6, 7, 8}, 9,    1, 0, 0, 0);
    add_row(CMD_READ,   0, '{0, 0, 0, 0, 0, 0, 0, 0}, 1024, 1, 0, 0, 0);
    add_row(CMD_UPDATE, 8, '{8, 7, 6, 5, 4, 3, 2, 1}, 0,    1, 36, 0, 0);
    // heights never drop
    add_row(CMD_UPDATE, 2, '{8, 7, 0, 0, 0, 0, 0, 0}, 0,    1, 36, 0, 0);
    add_row(CMD_READ,   0, '{0, 0, 0, 0, 0, 0, 0, 0}, 8,    1, 36, 8, 0);
    add_row(CMD_UPDATE, 2, '{1024, 1024, 0, 0, 0, 0, 0, 0}, 0, 0, 0, 0, 0);
    add_row(CMD_UPDATE, 9, '{2047, 2046, 1, 1024, 0, 0, 0, 0}, 0, 0, 0, 0, 0);
    add_row(CMD_READ,   0, '{0, 0, 0, 0, 0, 0, 0, 0}, 2047, 0, 0, 0, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_element(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].res);

    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      write_active_size(LABEL_W'(sizes[p]));
      quiet = (p == PHASES - 1);
      for (int n = 0; n < lens[p]; n++)
        send_element(random_element(), 1'b0, none);
    end

    drain_and_settle();
    repeat (32) @(posedge clk);
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!quiet && stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    profile_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, total", out_total_length, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_total_length !== want.total)
          report_mismatch("total_length", out_total_length, want.total);
        if (out_column_height !== want.height)
          report_mismatch("column_height", out_column_height, want.height);
        if (out_range_error !== want.err)
          report_mismatch("range_error", out_range_error, want.err);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
